// File: src/ter_pkg.sv
// ----------------------------------------------------------------------------
// ter_pkg
// shared types and codes of the triangle edge rasterizer
// ----------------------------------------------------------------------------
package ter_pkg;

  // fixed field widths
  localparam int FRAME_W  = 13;
  localparam int PIX_W    = 12;
  localparam int NUM_W    = 30;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // frame size limits and reset values
  localparam logic [FRAME_W-1:0] FRAME_LIMIT        = 13'd4096;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PIXEL  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd3;

  // clamped bounding box, upper bounds exclusive
  typedef struct packed {
    logic [FRAME_W-1:0] min_x;
    logic [FRAME_W-1:0] max_x;
    logic [FRAME_W-1:0] min_y;
    logic [FRAME_W-1:0] max_y;
  } box_t;

endpackage

// File: src/ter_front.sv
// ----------------------------------------------------------------------------
// ter_front
// input side: frame size registers, input handshake, bounding box setup
// ----------------------------------------------------------------------------
module ter_front #(
  parameter int COORD_BITS = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ter_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ter_pkg::FRAME_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   vert [6],
  input  logic                           q_full,
  output logic                           q_push,
  output ter_pkg::box_t                  box
);
  import ter_pkg::*;

  localparam int XW = (COORD_BITS > FRAME_W ? COORD_BITS : FRAME_W) + 1;

  logic [FRAME_W-1:0]    frame_width;
  logic [FRAME_W-1:0]    frame_height;
  logic [FRAME_W-1:0]    eff_w;
  logic [FRAME_W-1:0]    eff_h;
  logic signed [XW-1:0]  vx [3];
  logic signed [XW-1:0]  vy [3];
  logic signed [XW-1:0]  min_x, max_x, min_y, max_y;

  // clamp a coordinate to 0..hi
  function automatic logic [FRAME_W-1:0] clamp_coord(input logic signed [XW-1:0] v,
                                                     input logic [FRAME_W-1:0] hi);
    logic signed [XW-1:0] hi_s;
    hi_s = $signed(XW'(hi));
    if (v < 0) return '0;
    else if (v > hi_s) return hi;
    else return v[FRAME_W-1:0];
  endfunction

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_w = (frame_width > FRAME_LIMIT) ? FRAME_LIMIT : frame_width;
  assign eff_h = (frame_height > FRAME_LIMIT) ? FRAME_LIMIT : frame_height;

  // vertex min and max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = XW'(vert[2*i]);
      vy[i] = XW'(vert[2*i+1]);
    end
    min_x = vx[0];
    max_x = vx[0];
    min_y = vy[0];
    max_y = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < min_x) min_x = vx[i];
      if (vx[i] > max_x) max_x = vx[i];
      if (vy[i] < min_y) min_y = vy[i];
      if (vy[i] > max_y) max_y = vy[i];
    end
  end

  // box clamped to the frame
  always_comb begin
    box.min_x = clamp_coord(min_x, eff_w);
    box.max_x = clamp_coord(max_x, eff_w);
    box.min_y = clamp_coord(min_y, eff_h);
    box.max_y = clamp_coord(max_y, eff_h);
  end

  // input handshake into the queue
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: src/ter_queue.sv
// ----------------------------------------------------------------------------
// ter_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
module ter_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// File: src/ter_back.sv
// ----------------------------------------------------------------------------
// ter_back
// triangle setup on a shared multiplier, incremental edge scan, result register
// ----------------------------------------------------------------------------
module ter_back #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  logic                                q_func,
  input  ter_pkg::box_t                       q_box,
  input  logic signed [COORD_BITS-1:0]        q_vert [6],
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ter_pkg::STATUS_W-1:0]        status,
  output logic [ter_pkg::PIX_W-1:0]           pixel_x,
  output logic [ter_pkg::PIX_W-1:0]           pixel_y,
  output logic signed [ter_pkg::NUM_W-1:0]    weight0_num,
  output logic signed [ter_pkg::NUM_W-1:0]    weight1_num,
  output logic signed [ter_pkg::NUM_W-1:0]    weight2_num,
  output logic signed [ter_pkg::NUM_W-1:0]    tri_area
);
  import ter_pkg::*;

  localparam int XW = (COORD_BITS > FRAME_W ? COORD_BITS : FRAME_W) + 1;
  localparam int DW = XW + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;

  localparam logic [3:0] MUL_STEPS = 4'd8;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MUL    = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0]           state, state_next;
  logic                 tri_active, tri_active_next;
  logic [3:0]           mul_cnt;

  logic signed [XW-1:0] vx [3];
  logic signed [XW-1:0] vy [3];
  logic signed [DW-1:0] coef_a [3];
  logic signed [DW-1:0] coef_b [3];
  logic signed [DW-1:0] new_a [3];
  logic signed [DW-1:0] new_b [3];
  box_t                 box;
  logic signed [PW-1:0] prod;
  logic signed [EW-1:0] acc;
  logic signed [EW-1:0] area;
  logic signed [EW-1:0] edge_val [3];
  logic signed [EW-1:0] row_val [3];
  logic [FRAME_W-1:0]   scan_x, scan_y;

  logic [1:0]           eval_sel, edge_sel;
  logic                 term_sel;
  logic [3:0]           prev_cnt;
  logic signed [XW-1:0] base_x, base_y;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [EW-1:0] acc_sum;

  logic can_emit, area_neg, covered, in_rows, in_cols;
  logic do_load, do_mul, idle_done, decide_emit;
  logic scan_done, scan_row, scan_hit, scan_miss;
  logic emit_pixel, emit_done, emit_any, advance_x;

  // edge coefficients of a new triangle, edge e runs from vertex e to e+1
  always_comb begin
    new_a[0] = DW'(q_vert[3]) - DW'(q_vert[1]);
    new_a[1] = DW'(q_vert[5]) - DW'(q_vert[3]);
    new_a[2] = DW'(q_vert[1]) - DW'(q_vert[5]);
    new_b[0] = DW'(q_vert[0]) - DW'(q_vert[2]);
    new_b[1] = DW'(q_vert[2]) - DW'(q_vert[4]);
    new_b[2] = DW'(q_vert[4]) - DW'(q_vert[0]);
  end

  // multiplier operand selection: area, then each edge at the box corner
  always_comb begin
    eval_sel = mul_cnt[2:1];
    term_sel = mul_cnt[0];
    edge_sel = (eval_sel == 2'd0) ? 2'd0 : eval_sel - 2'd1;
    base_x   = (eval_sel == 2'd0) ? vx[2] : $signed(XW'(box.min_x));
    base_y   = (eval_sel == 2'd0) ? vy[2] : $signed(XW'(box.min_y));
    if (term_sel) begin
      mul_a = coef_b[edge_sel];
      mul_b = DW'(base_y) - DW'(vy[edge_sel]);
    end else begin
      mul_a = coef_a[edge_sel];
      mul_b = DW'(base_x) - DW'(vx[edge_sel]);
    end
    prev_cnt = mul_cnt - 4'd1;
    acc_sum  = acc + EW'(prod);
  end

  // action decode
  always_comb begin
    can_emit    = !out_valid || out_ready;
    area_neg    = area[EW-1];
    covered     = !edge_val[0][EW-1] && !edge_val[1][EW-1] && !edge_val[2][EW-1];
    in_rows     = scan_y < box.max_y;
    in_cols     = scan_x < box.max_x;
    q_pop       = (state == S_IDLE) && q_valid &&
                  ((q_func == FUNC_LOAD) || tri_active || can_emit);
    do_load     = q_pop && (q_func == FUNC_LOAD);
    idle_done   = q_pop && (q_func == FUNC_STEP) && !tri_active;
    do_mul      = (state == S_MUL);
    decide_emit = (state == S_DECIDE) && can_emit;
    scan_done   = (state == S_SCAN) && !in_rows;
    scan_row    = (state == S_SCAN) && in_rows && !in_cols;
    scan_hit    = (state == S_SCAN) && in_rows && in_cols && covered;
    scan_miss   = (state == S_SCAN) && in_rows && in_cols && !covered;
    emit_pixel  = scan_hit && can_emit;
    emit_done   = idle_done || (scan_done && can_emit);
    emit_any    = emit_pixel || emit_done || decide_emit;
    advance_x   = scan_miss || emit_pixel;
  end

  // next state
  always_comb begin
    state_next      = state;
    tri_active_next = tri_active;
    unique case (state)
      S_IDLE: begin
        if (do_load) state_next = S_MUL;
        else if (q_pop && tri_active) state_next = S_SCAN;
      end
      S_MUL: begin
        if (mul_cnt == MUL_STEPS) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (can_emit) begin
          state_next      = S_IDLE;
          tri_active_next = !area_neg;
        end
      end
      S_SCAN: begin
        if (emit_pixel) begin
          state_next = S_IDLE;
        end else if (scan_done && can_emit) begin
          state_next      = S_IDLE;
          tri_active_next = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tri_active <= 1'b0;
      mul_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      tri_active <= tri_active_next;
      if (do_load) mul_cnt <= '0;
      else if (do_mul && mul_cnt != MUL_STEPS) mul_cnt <= mul_cnt + 4'd1;
      if (emit_any) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // triangle setup and scan datapath
  always_ff @(posedge clk) begin
    if (do_load) begin
      for (int i = 0; i < 3; i++) begin
        vx[i]     <= XW'(q_vert[2*i]);
        vy[i]     <= XW'(q_vert[2*i+1]);
        coef_a[i] <= new_a[i];
        coef_b[i] <= new_b[i];
      end
      box <= q_box;
    end
    // multiply one term, then add it in the next cycle
    if (do_mul) begin
      if (mul_cnt != MUL_STEPS) prod <= mul_a * mul_b;
      if (mul_cnt != 4'd0) begin
        if (!prev_cnt[0]) begin
          acc <= EW'(prod);
        end else begin
          case (prev_cnt[2:1])
            2'd0:    area        <= acc_sum;
            2'd1:    edge_val[0] <= acc_sum;
            2'd2:    edge_val[1] <= acc_sum;
            default: edge_val[2] <= acc_sum;
          endcase
        end
      end
    end
    // start of scan at the box corner
    if (decide_emit && !area_neg) begin
      scan_x <= box.min_x;
      scan_y <= box.min_y;
      for (int e = 0; e < 3; e++) row_val[e] <= edge_val[e];
    end
    // next row
    if (scan_row) begin
      scan_x <= box.min_x;
      scan_y <= scan_y + 1'b1;
      for (int e = 0; e < 3; e++) begin
        row_val[e]  <= row_val[e] + EW'(coef_b[e]);
        edge_val[e] <= row_val[e] + EW'(coef_b[e]);
      end
    end
    // next pixel in the row
    if (advance_x) begin
      scan_x <= scan_x + 1'b1;
      for (int e = 0; e < 3; e++) edge_val[e] <= edge_val[e] + EW'(coef_a[e]);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_any) begin
      if (emit_pixel) status <= ST_PIXEL;
      else if (decide_emit) status <= area_neg ? ST_CULL : ST_ACCEPT;
      else status <= ST_DONE;
      pixel_x     <= emit_pixel ? scan_x[PIX_W-1:0] : '0;
      pixel_y     <= emit_pixel ? scan_y[PIX_W-1:0] : '0;
      weight0_num <= emit_pixel ? NUM_W'(edge_val[1]) : '0;
      weight1_num <= emit_pixel ? NUM_W'(edge_val[2]) : '0;
      weight2_num <= emit_pixel ? NUM_W'(edge_val[0]) : '0;
      tri_area    <= (emit_pixel || decide_emit) ? NUM_W'(area) : '0;
    end
  end

endmodule

// File: src/triangle_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_edge_rasterizer
// edge-function triangle rasterizer: load, cull, box setup and pixel scan
// ----------------------------------------------------------------------------
// a load runs through one shared multiplier, which forms the area and three corner
//   edge values in turn, then a decide step issues the accept or cull result
// a step tests pixels row by row and answers at a covered pixel or when the box
//   runs out; with no triangle it answers straight from the idle state
// one transaction at a time in the back, the next one is taken from the queue
//   only after a result issues; reset: frame 640 x 480, no triangle loaded
module triangle_edge_rasterizer #(
  parameter int COORD_BITS  = 13,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ter_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ter_pkg::FRAME_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [COORD_BITS-1:0]        vert0_x,
  input  logic signed [COORD_BITS-1:0]        vert0_y,
  input  logic signed [COORD_BITS-1:0]        vert1_x,
  input  logic signed [COORD_BITS-1:0]        vert1_y,
  input  logic signed [COORD_BITS-1:0]        vert2_x,
  input  logic signed [COORD_BITS-1:0]        vert2_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ter_pkg::STATUS_W-1:0]        status,
  output logic [ter_pkg::PIX_W-1:0]           pixel_x,
  output logic [ter_pkg::PIX_W-1:0]           pixel_y,
  output logic signed [ter_pkg::NUM_W-1:0]    weight0_num,
  output logic signed [ter_pkg::NUM_W-1:0]    weight1_num,
  output logic signed [ter_pkg::NUM_W-1:0]    weight2_num,
  output logic signed [ter_pkg::NUM_W-1:0]    tri_area
);
  import ter_pkg::*;

  localparam int Q_W = 1 + $bits(box_t) + 6 * COORD_BITS;

  logic signed [COORD_BITS-1:0] in_vert [6];
  logic signed [COORD_BITS-1:0] q_vert [6];
  box_t                         f_box;
  box_t                         q_box;
  logic                         q_func;
  logic                         q_push, q_full, q_pop, q_valid;
  logic [Q_W-1:0]               q_din, q_dout;

  assign in_vert[0] = vert0_x;
  assign in_vert[1] = vert0_y;
  assign in_vert[2] = vert1_x;
  assign in_vert[3] = vert1_y;
  assign in_vert[4] = vert2_x;
  assign in_vert[5] = vert2_y;

  // front: configuration, input handshake, box setup
  ter_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vert      (in_vert),
    .q_full    (q_full),
    .q_push    (q_push),
    .box       (f_box)
  );

  // command queue entry packing
  assign q_din = {func, f_box, in_vert[0], in_vert[1], in_vert[2],
                  in_vert[3], in_vert[4], in_vert[5]};
  assign {q_func, q_box, q_vert[0], q_vert[1], q_vert[2],
          q_vert[3], q_vert[4], q_vert[5]} = q_dout;

  ter_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  // back: triangle setup, scan and result register
  ter_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_func      (q_func),
    .q_box       (q_box),
    .q_vert      (q_vert),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .weight0_num (weight0_num),
    .weight1_num (weight1_num),
    .weight2_num (weight2_num),
    .tri_area    (tri_area)
  );

endmodule

// File: verif/tb_triangle_edge_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_triangle_edge_rasterizer
// self-checking testbench for the edge-function triangle rasterizer
// ----------------------------------------------------------------------------
// Drives load and step transactions through valid/ready with random gaps and
// output stalls. A scoreboard class predicts every result from its own copy of
// the vertices, box and scan position, and compares results field by field.
// A directed part covers the cull, zero-area, empty-box and clamping cases.
// Random phases follow over several frame sizes, including 0, 1, 4096 and
// values above 4096. Most random traffic loads a triangle and then walks its
// pixels.
// ----------------------------------------------------------------------------
module tb_triangle_edge_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import ter_pkg::*;

  localparam int COORD_W = 13;
  localparam longint COORD_MAX = 4095;
  localparam longint COORD_MIN = -4096;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 20;
  localparam longint SMALL_FRAME_PIXELS = 1024;
  localparam int MAX_PRINTED = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [FRAME_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_LOAD;
  logic signed [COORD_W-1:0] vert0_x = '0;
  logic signed [COORD_W-1:0] vert0_y = '0;
  logic signed [COORD_W-1:0] vert1_x = '0;
  logic signed [COORD_W-1:0] vert1_y = '0;
  logic signed [COORD_W-1:0] vert2_x = '0;
  logic signed [COORD_W-1:0] vert2_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic signed [NUM_W-1:0] weight0_num;
  logic signed [NUM_W-1:0] weight1_num;
  logic signed [NUM_W-1:0] weight2_num;
  logic signed [NUM_W-1:0] tri_area;

  bit calm = 1'b0;
  int items_sent = 0;
  int idle_count = 0;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic signed [NUM_W-1:0] w0;
    logic signed [NUM_W-1:0] w1;
    logic signed [NUM_W-1:0] w2;
    logic signed [NUM_W-1:0] area;
  } raster_result_t;

  triangle_edge_rasterizer dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // edge function of point c against the directed edge a -> b
  function automatic longint edge_value(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy);
    return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
  endfunction

  // frame register values above the limit act as the limit
  function automatic longint frame_extent(longint r);
    return (r > longint'(FRAME_LIMIT)) ? longint'(FRAME_LIMIT) : r;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel predictor and result scoreboard
  // ---------------------------------------------------------------------------
  class raster_scoreboard;
    raster_result_t expected_q[$];
    int errors;
    longint frame_w, frame_h;
    longint vx[3], vy[3];
    longint area, min_x, max_x, min_y, max_y, scan_x, scan_y;
    bit tri_loaded;

    function new();
      errors = 0;
      frame_w = FRAME_WIDTH_RESET;
      frame_h = FRAME_HEIGHT_RESET;
      foreach (vx[i]) begin
        vx[i] = 0;
        vy[i] = 0;
      end
      area = 0;
      min_x = 0;
      max_x = 0;
      min_y = 0;
      max_y = 0;
      scan_x = 0;
      scan_y = 0;
      tri_loaded = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
      if (idx == CFG_FRAME_WIDTH) begin
        frame_w = data;
      end else begin
        frame_h = data;
      end
    endfunction

    function longint clamp_range(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint min3(longint a, longint b, longint c);
      longint m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
    endfunction

    function longint max3(longint a, longint b, longint c);
      longint m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
    endfunction

    function void expect_result(logic [STATUS_W-1:0] st, longint px, longint py,
                                longint w0, longint w1, longint w2, longint a);
      raster_result_t r;
      r.status = st;
      r.px = px;
      r.py = py;
      r.w0 = w0;
      r.w1 = w1;
      r.w2 = w2;
      r.area = a;
      expected_q.push_back(r);
    endfunction

    function bit pixel_inside(longint x, longint y);
      return edge_value(vx[0], vy[0], vx[1], vy[1], x, y) >= 0 &&
             edge_value(vx[1], vy[1], vx[2], vy[2], x, y) >= 0 &&
             edge_value(vx[2], vy[2], vx[0], vy[0], x, y) >= 0;
    endfunction

    // update state for one accepted transaction and queue its result
    function void note_item(logic fn, logic signed [COORD_W-1:0] x0,
                            logic signed [COORD_W-1:0] y0, logic signed [COORD_W-1:0] x1,
                            logic signed [COORD_W-1:0] y1, logic signed [COORD_W-1:0] x2,
                            logic signed [COORD_W-1:0] y2);
      longint a, w, h, x, y;
      bit found;
      if (fn == FUNC_LOAD) begin
        a = edge_value(x0, y0, x1, y1, x2, y2);
        // back-facing triangles are dropped, old vertices stay
        if (a < 0) begin
          tri_loaded = 1'b0;
          expect_result(ST_CULL, 0, 0, 0, 0, 0, a);
          return;
        end
        vx[0] = x0;
        vy[0] = y0;
        vx[1] = x1;
        vy[1] = y1;
        vx[2] = x2;
        vy[2] = y2;
        area = a;
        w = frame_extent(frame_w);
        h = frame_extent(frame_h);
        min_x = clamp_range(min3(vx[0], vx[1], vx[2]), 0, w);
        max_x = clamp_range(max3(vx[0], vx[1], vx[2]), 0, w);
        min_y = clamp_range(min3(vy[0], vy[1], vy[2]), 0, h);
        max_y = clamp_range(max3(vy[0], vy[1], vy[2]), 0, h);
        scan_x = min_x;
        scan_y = min_y;
        tri_loaded = 1'b1;
        expect_result(ST_ACCEPT, 0, 0, 0, 0, 0, a);
      end else if (!tri_loaded) begin
        expect_result(ST_DONE, 0, 0, 0, 0, 0, 0);
      end else begin
        // row-major walk to the next covered pixel
        found = 1'b0;
        x = scan_x;
        y = scan_y;
        while (!found && y < max_y) begin
          if (x >= max_x) begin
            y++;
            x = min_x;
          end else if (pixel_inside(x, y)) begin
            found = 1'b1;
          end else begin
            x++;
          end
        end
        if (found) begin
          scan_x = x + 1;
          scan_y = y;
          expect_result(ST_PIXEL, x, y,
                        edge_value(vx[1], vy[1], vx[2], vy[2], x, y),
                        edge_value(vx[2], vy[2], vx[0], vy[0], x, y),
                        edge_value(vx[0], vy[0], vx[1], vy[1], x, y), area);
        end else begin
          scan_x = min_x;
          scan_y = max_y;
          tri_loaded = 1'b0;
          expect_result(ST_DONE, 0, 0, 0, 0, 0, 0);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endtask

    task compare_field(string name, logic signed [63:0] got_val,
                       logic signed [63:0] want_val);
      if (got_val !== want_val) begin
        report($sformatf("%s got %0d expected %0d", name, got_val, want_val));
      end
    endtask

    task check_result(raster_result_t got);
      raster_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with status %0d and nothing expected", got.status));
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("pixel_x", got.px, want.px);
      compare_field("pixel_y", got.py, want.py);
      compare_field("weight0_num", got.w0, want.w0);
      compare_field("weight1_num", got.w1, want.w1);
      compare_field("weight2_num", got.w2, want.w2);
      compare_field("tri_area", got.area, want.area);
    endtask
  endclass

  raster_scoreboard sb = new();

  // gap lengths: mostly short, a few long, none in calm stretches
  function automatic int gap_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    logic [31:0] r;
    r = $urandom();
    return r[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord(longint base, int spread);
    longint v;
    v = base + longint'($urandom_range(0, spread));
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  task automatic send_item(logic fn, logic signed [COORD_W-1:0] x0,
                           logic signed [COORD_W-1:0] y0, logic signed [COORD_W-1:0] x1,
                           logic signed [COORD_W-1:0] y1, logic signed [COORD_W-1:0] x2,
                           logic signed [COORD_W-1:0] y2);
    in_valid <= 1'b1;
    func <= fn;
    vert0_x <= x0;
    vert0_y <= y0;
    vert1_x <= x1;
    vert1_y <= y1;
    vert2_x <= x2;
    vert2_y <= y2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(fn, x0, y0, x1, y1, x2, y2);
    items_sent++;
  endtask

  task automatic idle_sender();
    int n;
    n = gap_cycles();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic load_triangle(logic signed [COORD_W-1:0] x0, logic signed [COORD_W-1:0] y0,
                               logic signed [COORD_W-1:0] x1, logic signed [COORD_W-1:0] y1,
                               logic signed [COORD_W-1:0] x2, logic signed [COORD_W-1:0] y2);
    send_item(FUNC_LOAD, x0, y0, x1, y1, x2, y2);
    idle_sender();
  endtask

  // vertex fields are ignored on a step, so they carry junk
  task automatic step_item();
    send_item(FUNC_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord());
    idle_sender();
  endtask

  // hold off until every expected result is back and the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame(logic [FRAME_W-1:0] w, logic [FRAME_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    sb.write_reg(CFG_FRAME_WIDTH, w);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    sb.write_reg(CFG_FRAME_HEIGHT, h);
    cfg_write <= 1'b0;
  endtask

  // load one triangle and walk its pixels, sometimes abandoning it early
  task automatic run_triangle();
    logic signed [COORD_W-1:0] c[6];
    logic signed [COORD_W-1:0] t;
    longint w, h, bx, by;
    int spread, cap, n;
    bit full;
    w = frame_extent(sb.frame_w);
    h = frame_extent(sb.frame_h);
    calm = ($urandom_range(0, 4) == 0);
    full = (w * h <= SMALL_FRAME_PIXELS) && ($urandom_range(0, 1) == 1);
    spread = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(0, 10);
    if (full) begin
      foreach (c[i]) c[i] = any_coord();
    end else begin
      bx = longint'($urandom_range(0, w + 16)) - 12;
      by = longint'($urandom_range(0, h + 16)) - 12;
      for (int i = 0; i < 3; i++) begin
        c[2*i] = near_coord(bx, spread);
        c[2*i+1] = near_coord(by, spread);
      end
    end
    // degenerate triangle, or mostly front-facing otherwise
    if ($urandom_range(0, 11) == 0) begin
      c[4] = c[2];
      c[5] = c[3];
    end else if ($urandom_range(0, 4) != 0 &&
                 edge_value(c[0], c[1], c[2], c[3], c[4], c[5]) < 0) begin
      t = c[2];
      c[2] = c[4];
      c[4] = t;
      t = c[3];
      c[3] = c[5];
      c[5] = t;
    end
    load_triangle(c[0], c[1], c[2], c[3], c[4], c[5]);
    if (full) cap = $urandom_range(1, 30);
    else if (spread == 64) cap = $urandom_range(5, 40);
    else cap = 200;
    if ($urandom_range(0, 7) == 0) cap = $urandom_range(1, 4);
    n = 0;
    while (sb.tri_loaded && n < cap) begin
      step_item();
      n++;
    end
    if (!sb.tri_loaded && $urandom_range(0, 3) == 0) step_item();
  endtask

  // lone transactions outside a normal load-and-walk sequence
  task automatic noise_item();
    if (!sb.tri_loaded) begin
      step_item();
    end else begin
      load_triangle(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                    any_coord());
    end
  endtask

  task automatic run_phase(logic [FRAME_W-1:0] w, logic [FRAME_W-1:0] h, int count);
    int phase_end;
    wait_drained();
    write_frame(w, h);
    phase_end = items_sent + count;
    while (items_sent < phase_end) begin
      if ($urandom_range(0, 7) == 0) noise_item();
      else run_triangle();
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result sink with random stalls
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    raster_result_t got;
    stall_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.status = status;
        got.px = pixel_x;
        got.py = pixel_y;
        got.w0 = weight0_num;
        got.w1 = weight1_num;
        got.w2 = weight2_num;
        got.area = tri_area;
        sb.check_result(got);
      end
      if (stall_left == 0) stall_left = gap_cycles();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count = 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset frame size
    step_item();                                        // step with nothing loaded
    load_triangle(2, 2, 6, 2, 2, 6);                    // back-facing, culled
    step_item();                                        // step after a cull
    load_triangle(2, 2, 2, 6, 6, 2);
    repeat (3) step_item();
    load_triangle(-4096, -4096, -4096, 4095, 4095, 4095);  // extremes, clamped box
    step_item();
    load_triangle(4095, 4095, 4095, 4095, 4095, 4095);  // zero area, box beyond frame
    repeat (2) step_item();
    load_triangle(1, 1, 3, 3, 5, 5);                    // zero area on a diagonal
    repeat (2) step_item();
    load_triangle(4095, 4095, -4096, 4095, 4095, -4096);   // largest negative area
    step_item();
    load_triangle(636, 476, 636, 484, 644, 476);        // crosses the frame corner
    repeat (3) step_item();

    // random phases over frame sizes
    run_phase(13'd640, 13'd480, 100);
    run_phase(13'd16, 13'd16, 70);
    run_phase(13'd4096, 13'd4096, 90);
    run_phase(13'd1, 13'd1, 35);
    run_phase(13'd8191, 13'd8191, 50);
    run_phase(13'd0, 13'd17, 25);
    run_phase(13'd23, 13'd0, 25);
    run_phase(13'd4096, 13'd1, 50);
    run_phase(13'd1, 13'd4096, 50);
    run_phase(13'd100, 13'd60, 90);
    run_phase(13'd640, 13'd480, 60);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
